/* hw/rtl/som_pkg.sv */
`default_nettype none

package som_pkg;

  localparam int IDX_W    = 8;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 32;
  localparam int COORD_W  = 8;
  localparam int SPAN_W   = 9;
  localparam int RATE_W   = 21;
  localparam int RATE_FRAC = 20;
  localparam int CFG_W    = 9;
  localparam int REG_IDX_W = 2;
  localparam int CMP_W    = 12;

  // queue between classifier and update pipe; depth kept a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRAIN = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NODE_ROW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SPAN = 2'd2;

  localparam logic [SPAN_W-1:0] GRID_SPAN_RST = 9'd16;

  // schedule phase bounds on the iteration count
  localparam logic [COUNT_W-1:0] CNT_T100   = 32'd100;
  localparam logic [COUNT_W-1:0] CNT_T100K  = 32'd100000;
  localparam logic [COUNT_W-1:0] CNT_T500K  = 32'd500000;
  localparam logic [COUNT_W-1:0] CNT_T1M    = 32'd1000000;
  localparam logic [COUNT_W-1:0] CNT_T1M5   = 32'd1500000;
  localparam logic [COUNT_W-1:0] CNT_T2M    = 32'd2000000;
  localparam logic [COUNT_W-1:0] CNT_T3M2   = 32'd3200000;
  localparam logic [COUNT_W-1:0] CNT_T4M    = 32'd4000000;
  localparam logic [COUNT_W-1:0] PHASE1_END = 32'd5000000;
  localparam logic [COUNT_W-1:0] PHASE2_END = 32'd10000000;

  // learning rates, Q1.20 rounded to nearest
  localparam logic [RATE_W-1:0] RATE_ONE    = 21'd1048576;
  localparam logic [RATE_W-1:0] RATE_0P9    = 21'd943718;
  localparam logic [RATE_W-1:0] RATE_0P7    = 21'd734003;
  localparam logic [RATE_W-1:0] RATE_0P5    = 21'd524288;
  localparam logic [RATE_W-1:0] RATE_0P3    = 21'd314573;
  localparam logic [RATE_W-1:0] RATE_0P1    = 21'd104858;
  localparam logic [RATE_W-1:0] RATE_0P01   = 21'd10486;
  localparam logic [RATE_W-1:0] RATE_0P009  = 21'd9437;
  localparam logic [RATE_W-1:0] RATE_0P008  = 21'd8389;
  localparam logic [RATE_W-1:0] RATE_0P007  = 21'd7340;
  localparam logic [RATE_W-1:0] RATE_0P006  = 21'd6291;
  localparam logic [RATE_W-1:0] RATE_0P005  = 21'd5243;
  localparam logic [RATE_W-1:0] RATE_0P001  = 21'd1049;
  localparam logic [RATE_W-1:0] RATE_0P0005 = 21'd524;
  localparam logic [RATE_W-1:0] RATE_0P0001 = 21'd105;

  typedef struct packed {
    logic                       action;
    logic [IDX_W-1:0]           idx;
    logic signed [WEIGHT_W-1:0] sample;
    logic [RATE_W-1:0]          rate;
    logic                       in_range;
    logic                       last;
  } som_item_t;

endpackage

`default_nettype wire

/* hw/rtl/som_front.sv */
`default_nettype none

module som_front import som_pkg::*; #(
  parameter int VECTOR_LEN = 256,
  parameter int COORD_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [IDX_W-1:0]           element_index,
  input  logic signed [WEIGHT_W-1:0] sample_value,
  input  logic [COUNT_W-1:0]         iteration_count,
  input  logic [COORD_W-1:0]         winner_col,
  input  logic [COORD_W-1:0]         winner_row,
  input  logic                       last_element,
  input  logic                       q_full,
  output logic                       push,
  output som_item_t                  item
);

  localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int ADDR_BITS = $clog2(VECTOR_LEN);
  localparam int EXT_BITS = (ADDR_BITS > IDX_W) ? ADDR_BITS : IDX_W;

  logic [COORD_W-1:0] node_col;
  logic [COORD_W-1:0] node_row;
  logic [SPAN_W-1:0]  grid_span;

  logic [CB-1:0]    dc;
  logic [CB-1:0]    dr;
  logic [CB:0]      hop_dist;
  logic [CMP_W-1:0] d12;
  logic [CMP_W-1:0] d1;
  logic [CMP_W-1:0] h12;
  logic [RATE_W-1:0] rate;
  logic             in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_col  <= '0;
      node_row  <= '0;
      grid_span <= GRID_SPAN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NODE_COL:  node_col  <= cfg_data[COORD_W-1:0];
        REG_NODE_ROW:  node_row  <= cfg_data[COORD_W-1:0];
        REG_GRID_SPAN: grid_span <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    dc = (node_col[CB-1:0] > winner_col[CB-1:0]) ?
         node_col[CB-1:0] - winner_col[CB-1:0] : winner_col[CB-1:0] - node_col[CB-1:0];
    dr = (node_row[CB-1:0] > winner_row[CB-1:0]) ?
         node_row[CB-1:0] - winner_row[CB-1:0] : winner_row[CB-1:0] - node_row[CB-1:0];
    hop_dist = {1'b0, dc} + {1'b0, dr};
  end

  assign d12 = CMP_W'(hop_dist);
  assign d1  = d12 + CMP_W'(1);
  assign h12 = CMP_W'(grid_span);

  // d < floor(H/k) is the same as k*(d+1) <= H
  always_comb begin
    if (iteration_count < PHASE1_END) begin
      priority if (iteration_count <= CNT_T100 && d12 * 12'd2 < h12 * 12'd3) rate = RATE_0P5;
      else if (iteration_count <= CNT_T100K && d12 < h12) rate = RATE_0P7;
      else if (iteration_count <= CNT_T500K && d12 * 12'd3 < h12 * 12'd2) rate = RATE_0P9;
      else if (iteration_count <= CNT_T1M && d1 * 12'd2 <= h12) rate = RATE_0P7;
      else if (iteration_count <= CNT_T1M5 && d1 * 12'd3 <= h12) rate = RATE_0P5;
      else if (iteration_count <= CNT_T2M && d1 * 12'd4 <= h12) rate = RATE_0P3;
      else if (iteration_count <= CNT_T3M2 && d1 * 12'd5 <= h12) rate = RATE_0P1;
      else if (iteration_count <= CNT_T4M && d1 * 12'd6 <= h12) rate = RATE_0P01;
      else if (d12 < 12'd4) rate = RATE_ONE;
      else rate = '0;
    end else if (iteration_count < PHASE2_END) begin
      priority if (d12 < 12'd4) rate = RATE_0P01;
      else if (d12 < 12'd6) rate = RATE_0P009;
      else if (d12 < 12'd8) rate = RATE_0P008;
      else if (d12 < 12'd10) rate = RATE_0P007;
      else if (d12 < 12'd12) rate = RATE_0P006;
      else if (d12 < 12'd16) rate = RATE_0P005;
      else rate = '0;
    end else begin
      priority if (d12 == 12'd0) rate = RATE_0P001;
      else if (d12 < 12'd3) rate = RATE_0P0005;
      else if (d12 == 12'd3) rate = RATE_0P0001;
      else rate = '0;
    end
  end

  assign in_range = {1'b0, EXT_BITS'(element_index)} < (EXT_BITS + 1)'(VECTOR_LEN);

  always_comb begin
    item.action   = action;
    item.idx      = element_index;
    item.sample   = sample_value;
    item.rate     = (action == ACT_TRAIN && in_range) ? rate : '0;
    item.in_range = in_range;
    item.last     = last_element;
  end

endmodule

`default_nettype wire

/* hw/rtl/som_queue.sv */
`default_nettype none

module som_queue import som_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  som_item_t din,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output som_item_t head
);

  som_item_t slots [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + QCNT_W'(1);
    else if (pop && !push) count_next = count - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != QCNT_W'(QUEUE_DEPTH))
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

/* hw/rtl/som_back.sv */
`default_nettype none

module som_back import som_pkg::*; #(
  parameter int VECTOR_LEN = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  som_item_t                  head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_W-1:0]           element_index_out,
  output logic signed [WEIGHT_W-1:0] weight_value,
  output logic [RATE_W-1:0]          applied_rate,
  output logic                       updated,
  output logic                       done_res
);

  localparam int ADDR_BITS = $clog2(VECTOR_LEN);
  localparam int EXT_BITS  = (ADDR_BITS > IDX_W) ? ADDR_BITS : IDX_W;
  localparam int DIFF_W    = WEIGHT_W + 1;
  localparam int PROD_W    = DIFF_W + RATE_W + 1;
  localparam int SUM_W     = WEIGHT_W + 4;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (RATE_FRAC - 1);

  function automatic logic [ADDR_BITS-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(i);
    return e[ADDR_BITS-1:0];
  endfunction

  logic [WEIGHT_W-1:0] mem [VECTOR_LEN];

  logic adv;
  logic hazard;

  // read stage: item plus registered read data
  logic                m_valid;
  som_item_t           m;
  logic [WEIGHT_W-1:0] rd_data;
  logic signed [WEIGHT_W-1:0] m_w;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;

  // product stage
  logic                       p_valid;
  som_item_t                  p;
  logic signed [WEIGHT_W-1:0] p_w;
  logic signed [PROD_W-1:0]   p_prod;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [PROD_W-1:0]   q_full;
  logic signed [SUM_W-1:0]    sum;
  logic [SUM_W-WEIGHT_W:0]    sum_hi;
  logic signed [WEIGHT_W-1:0] sat_w;
  logic signed [WEIGHT_W-1:0] new_w;
  logic                       p_upd;
  logic                       wr_en;

  // last write, covers the read that raced it
  logic                wb_valid;
  logic [IDX_W-1:0]    wb_idx;
  logic [WEIGHT_W-1:0] wb_val;

  logic                       o_valid;
  logic [IDX_W-1:0]           o_idx;
  logic signed [WEIGHT_W-1:0] o_value;
  logic [RATE_W-1:0]          o_rate;
  logic                       o_upd;
  logic                       o_last;

  assign adv = !o_valid || !out_stall;
  // a training word right behind a word on the same element is held in the queue
  assign hazard = m_valid && head.action == ACT_TRAIN && m.idx == head.idx;
  assign pop = adv && q_valid && !hazard;

  assign m_w  = (wb_valid && wb_idx == m.idx) ? wb_val : rd_data;
  assign diff = DIFF_W'(m.sample) - DIFF_W'(m_w);
  assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, m.rate}));

  assign rounded = p_prod + ROUND_BIAS;
  assign q_full  = rounded >>> RATE_FRAC;
  assign sum     = SUM_W'(p_w) + q_full[SUM_W-1:0];
  assign sum_hi  = sum[SUM_W-1:WEIGHT_W-1];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      sat_w = sum[WEIGHT_W-1:0];
    end else begin
      sat_w = sum[SUM_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  always_comb begin
    p_upd = p.in_range && (p.action == ACT_LOAD || p.rate != '0);
    if (p.action == ACT_LOAD) new_w = p.sample;
    else if (p.rate != '0) new_w = sat_w;
    else new_w = p_w;
  end

  assign wr_en = adv && p_valid && p_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      p_valid  <= 1'b0;
      o_valid  <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      if (adv) begin
        m_valid <= pop;
        p_valid <= m_valid;
        o_valid <= p_valid;
      end
      if (wr_en) wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m       <= head;
      rd_data <= mem[to_addr(head.idx)];
    end
    if (adv) begin
      p      <= m;
      p_w    <= m_w;
      p_prod <= prod;
      o_idx   <= p.idx;
      o_value <= p.in_range ? new_w : '0;
      o_rate  <= p.rate;
      o_upd   <= p_upd;
      o_last  <= p.last;
    end
    if (wr_en) begin
      mem[to_addr(p.idx)] <= new_w;
      wb_idx <= p.idx;
      wb_val <= new_w;
    end
  end

  assign out_valid         = o_valid;
  assign element_index_out = o_idx;
  assign weight_value      = o_value;
  assign applied_rate      = o_rate;
  assign updated           = o_upd;
  assign done_res          = o_last;

`ifndef SYNTHESIS
  a_no_raw_overlap: assert property (@(posedge clk) disable iff (rst)
    m_valid && p_valid && m.action == ACT_TRAIN |-> m.idx != p.idx)
    else $error("training word overlaps pending write on same element");

  a_rate_means_update: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_rate != '0 |-> o_upd)
    else $error("nonzero rate reported without update");

  a_range_no_rate: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p.in_range |-> p.rate == '0 && !p_upd)
    else $error("out-of-range word carries rate or write");
`endif

endmodule

`default_nettype wire

/* hw/rtl/som_node_weight_update.sv */
// One self-organizing-map node holding a weight vector of VECTOR_LEN elements.
// Input channel (in_valid / in_stall): one word per element. action 0 loads
// the element with sample_value; action 1 trains it toward sample_value at a
// rate picked from iteration_count and the grid distance to the winner.
// Output channel (out_valid / out_stall): exactly one result word per input
// word, in order. Config port (cfg_write, cfg_index, cfg_data) sets node
// column, node row and grid span; write it only while the block is idle.
// Path: queue, read stage, product stage, output register. Throughput: one
// word per cycle while out_stall is low; a training word that directly follows
// a word on the same element waits in the queue, since the single multiply-add
// path must finish the previous write to that element first.
// Stall: the output register holds its word while out_stall is high and the
// update pipe freezes; a four-entry queue keeps taking input until full, then
// in_stall rises.
// Reset clears control and the queue and sets node 0,0 and span 16. The
// weight memory is not cleared: load every element before training it.
`default_nettype none

module som_node_weight_update import som_pkg::*; #(
  parameter int VECTOR_LEN = 256,
  parameter int COORD_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [IDX_W-1:0]           element_index,
  input  logic signed [WEIGHT_W-1:0] sample_value,
  input  logic [COUNT_W-1:0]         iteration_count,
  input  logic [COORD_W-1:0]         winner_col,
  input  logic [COORD_W-1:0]         winner_row,
  input  logic                       last_element,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_W-1:0]           element_index_out,
  output logic signed [WEIGHT_W-1:0] weight_value,
  output logic [RATE_W-1:0]          applied_rate,
  output logic                       updated,
  output logic                       done_res
);

  logic      q_full;
  logic      q_valid;
  logic      push;
  logic      pop;
  som_item_t item;
  som_item_t head;

  som_front #(
    .VECTOR_LEN(VECTOR_LEN),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .element_index  (element_index),
    .sample_value   (sample_value),
    .iteration_count(iteration_count),
    .winner_col     (winner_col),
    .winner_row     (winner_row),
    .last_element   (last_element),
    .q_full         (q_full),
    .push           (push),
    .item           (item)
  );

  som_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (item),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (head)
  );

  som_back #(
    .VECTOR_LEN(VECTOR_LEN)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .element_index_out(element_index_out),
    .weight_value     (weight_value),
    .applied_rate     (applied_rate),
    .updated          (updated),
    .done_res         (done_res)
  );

endmodule

`default_nettype wire
